>>> hw/rtl/rsrt_pkg.sv
// Package: widths, tree geometry and request codes for the slot reservation tree.
`default_nettype none
package rsrt_pkg;
   localparam int SLOT_BITS  = 13;
   localparam int NUM_SLOTS  = 1 << SLOT_BITS;
   localparam int OWNER_BITS = 16;
   localparam int NODE_BITS  = SLOT_BITS + 1;
   localparam int NODE_COUNT = 1 << NODE_BITS;
   localparam int DEPTH_BITS = $clog2(SLOT_BITS + 1);
   localparam int ENTRY_BITS = OWNER_BITS + 1;
   localparam int REQ_BITS   = ((2 * SLOT_BITS + OWNER_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = ((OWNER_BITS + 1 + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ACT_BOOK    = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_QUERY   = 2'd2,
      ACT_ASSIGN  = 2'd3
   } action_type;
endpackage
`default_nettype wire

>>> hw/rtl/range_slot_reservation_tree.sv
// Top level: lazy segment tree of slot owners held in one node memory.
//
//  channel | dir | payload
//  req     | in  | tuser: action; tdata: first_slot, last_slot, owner_id
//  rsp     | out | tdata: done_res, range_or
//
// Each word walks the tree twice from the root, first reading the range OR and then,
// if a change applies, writing the range; each node visit reads, examines and steps
// back, a pushed-down assignment writes both children and clears the parent's flag and
// each parent refresh reads both children and writes the parent, all through the single
// node memory. An empty range skips the walk and goes from the accept through the return
// and result states to the output register. After reset a clearing pass zeroes every
// entry of the node memory; no word is taken until it ends. A stalled result waits in the
// output register; the next word is taken once the walk has finished and its result is loaded.
`default_nettype none
module range_slot_reservation_tree (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // [12:0] first_slot, [25:13] last_slot, [41:26] owner_id, rest zero
   input  wire logic [rsrt_pkg::REQ_BITS-1:0] req_tdata,
   // [1:0] action
   input  wire logic [1:0]                   req_tuser,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // [0] done_res, [16:1] range_or, rest zero
   output logic [rsrt_pkg::RSP_BITS-1:0]     rsp_tdata
);
   localparam int SB = rsrt_pkg::SLOT_BITS;
   localparam int NB = rsrt_pkg::NODE_BITS;
   localparam int OB = rsrt_pkg::OWNER_BITS;
   localparam int DB = rsrt_pkg::DEPTH_BITS;
   localparam int EB = rsrt_pkg::ENTRY_BITS;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_VISIT, ST_FETCH, ST_PUSH_R, ST_PUSH_P,
      ST_RETURN, ST_REF_A, ST_REF_B, ST_REF_C, ST_RESULT
   } state_type;

   state_type              state_ff;
   logic                   write_pass_ff;
   logic [NB-1:0]          node_ff;
   logic [DB-1:0]          depth_ff;
   logic [NB-1:0]          clear_ff;
   rsrt_pkg::action_type   action_ff;
   logic [SB-1:0]          first_ff, last_ff;
   logic [OB-1:0]          owner_ff, value_ff, acc_ff, left_ff;
   logic                   empty_ff, done_ff;
   logic                   rsp_valid_ff;
   logic [OB:0]            rsp_data_ff;

   // node memory: {pending flag, subtree OR}
   logic [EB-1:0]          mem_ff [rsrt_pkg::NODE_COUNT];
   logic [EB-1:0]          rd_data_ff;
   logic                   mem_we, mem_re;
   logic [NB-1:0]          mem_waddr, mem_raddr;
   logic [EB-1:0]          mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[mem_raddr];
      end
   end

   // node span from index and depth
   logic [2*NB-1:0] shifted;
   logic [SB-1:0]   lo, hi, span;
   logic [DB-1:0]   shift_amt;
   logic            leaf, child_leaf, disjoint, covered;
   logic [OB-1:0]   rd_or;
   logic            rd_flag;
   logic [NB-1:0]   left_child, right_child;

   always_comb begin
      shift_amt   = DB'(SB) - depth_ff;
      shifted     = {{NB{1'b0}}, node_ff} << shift_amt;
      lo          = shifted[SB-1:0];
      span        = SB'(({{SB{1'b0}}, 1'b1} << shift_amt) - 1'b1);
      hi          = lo | span;
      leaf        = (depth_ff == DB'(SB));
      child_leaf  = (depth_ff == DB'(SB - 1));
      disjoint    = (hi < first_ff) || (lo > last_ff);
      covered     = (first_ff <= lo) && (hi <= last_ff);
      rd_or       = rd_data_ff[OB-1:0];
      rd_flag     = rd_data_ff[OB];
      left_child  = {node_ff[NB-2:0], 1'b0};
      right_child = {node_ff[NB-2:0], 1'b1};
   end

   // memory port control per state
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = node_ff;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = node_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clear_ff;
         end
         ST_VISIT: begin
            mem_re = 1'b1;
         end
         ST_FETCH: begin
            if (write_pass_ff && !disjoint) begin
               if (covered) begin
                  mem_we    = 1'b1;
                  mem_wdata = {!leaf, value_ff};
               end else if (rd_flag) begin
                  mem_we    = 1'b1;
                  mem_waddr = left_child;
                  mem_wdata = {!child_leaf, rd_or};
               end
            end
         end
         ST_PUSH_R: begin
            mem_we    = 1'b1;
            mem_waddr = right_child;
            mem_wdata = {!child_leaf, rd_or};
         end
         ST_PUSH_P: begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, rd_or};
         end
         ST_REF_A: begin
            mem_re    = 1'b1;
            mem_raddr = left_child;
         end
         ST_REF_B: begin
            mem_re    = 1'b1;
            mem_raddr = right_child;
         end
         ST_REF_C: begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, left_ff | rd_or};
         end
         default: begin
         end
      endcase
   end

   // decision after the read walk
   logic          apply;
   logic [OB-1:0] apply_value;
   always_comb begin
      apply       = 1'b0;
      apply_value = owner_ff;
      unique case (action_ff)
         rsrt_pkg::ACT_BOOK:    apply = (acc_ff == '0);
         rsrt_pkg::ACT_RELEASE: begin
            apply       = (acc_ff == owner_ff);
            apply_value = '0;
         end
         rsrt_pkg::ACT_QUERY:   apply = 1'b0;
         rsrt_pkg::ACT_ASSIGN:  apply = 1'b1;
      endcase
   end

   // sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         write_pass_ff <= 1'b0;
      end else begin
         // result taken; a new one is only loaded from the result state
         if (rsp_valid_ff && rsp_tready && state_ff != ST_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clear_ff <= clear_ff + 1'b1;
               if (clear_ff == NB'(rsrt_pkg::NODE_COUNT - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  action_ff     <= rsrt_pkg::action_type'(req_tuser);
                  first_ff      <= req_tdata[SB-1:0];
                  last_ff       <= req_tdata[2*SB-1:SB];
                  owner_ff      <= req_tdata[2*SB+OB-1:2*SB];
                  empty_ff      <= req_tdata[SB-1:0] > req_tdata[2*SB-1:SB];
                  acc_ff        <= '0;
                  write_pass_ff <= 1'b0;
                  node_ff       <= NB'(1);
                  depth_ff      <= '0;
                  state_ff      <= (req_tdata[SB-1:0] > req_tdata[2*SB-1:SB])
                                   ? ST_RETURN : ST_VISIT;
               end
            end
            ST_VISIT: begin
               state_ff <= ST_FETCH;
            end
            ST_FETCH: begin
               priority if (disjoint) begin
                  state_ff <= ST_RETURN;
               end else if (covered) begin
                  if (!write_pass_ff) begin
                     acc_ff <= acc_ff | rd_or;
                  end
                  state_ff <= ST_RETURN;
               end else if (rd_flag && !write_pass_ff) begin
                  // whole subtree holds one owner
                  acc_ff   <= acc_ff | rd_or;
                  state_ff <= ST_RETURN;
               end else if (rd_flag) begin
                  state_ff <= ST_PUSH_R;
               end else begin
                  node_ff  <= left_child;
                  depth_ff <= depth_ff + 1'b1;
                  state_ff <= ST_VISIT;
               end
            end
            ST_PUSH_R: begin
               state_ff <= ST_PUSH_P;
            end
            ST_PUSH_P: begin
               node_ff  <= left_child;
               depth_ff <= depth_ff + 1'b1;
               state_ff <= ST_VISIT;
            end
            ST_RETURN: begin
               priority if (node_ff == NB'(1)) begin
                  if (!write_pass_ff && apply && !empty_ff) begin
                     write_pass_ff <= 1'b1;
                     value_ff      <= apply_value;
                     done_ff       <= 1'b1;
                     depth_ff      <= '0;
                     state_ff      <= ST_VISIT;
                  end else if (!write_pass_ff) begin
                     done_ff  <= apply;
                     state_ff <= ST_RESULT;
                  end else begin
                     state_ff <= ST_RESULT;
                  end
               end else if (!node_ff[0]) begin
                  node_ff  <= node_ff + 1'b1;
                  state_ff <= ST_VISIT;
               end else begin
                  node_ff  <= node_ff >> 1;
                  depth_ff <= depth_ff - 1'b1;
                  state_ff <= write_pass_ff ? ST_REF_A : ST_RETURN;
               end
            end
            ST_REF_A: begin
               state_ff <= ST_REF_B;
            end
            ST_REF_B: begin
               left_ff  <= rd_or;
               state_ff <= ST_REF_C;
            end
            ST_REF_C: begin
               state_ff <= ST_RETURN;
            end
            ST_RESULT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {acc_ff, done_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rsrt_pkg::RSP_BITS - OB - 1){1'b0}}, rsp_data_ff};
endmodule
`default_nettype wire

>>> hw/rtl/rsrt_checker.sv
// Checker: port-level properties of the slot reservation tree, with its bind.
`default_nettype none
module rsrt_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_tvalid,
   input wire logic                         req_tready,
   input wire logic                         rsp_tvalid,
   input wire logic                         rsp_tready,
   input wire logic [rsrt_pkg::RSP_BITS-1:0] rsp_tdata
);
   // no result straight after reset
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result shown after reset");

   // clearing pass holds off requests after reset
   a_reset_busy: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // one word in flight: busy after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word taken during a walk");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");
endmodule

bind range_slot_reservation_tree rsrt_checker u_rsrt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

>>> tb/tb_range_slot_reservation_tree.sv
// Testbench: slot reservation tree checked against a flat per-slot owner array.
`default_nettype none
module tb_range_slot_reservation_tree;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // [12:0] first_slot, [25:13] last_slot, [41:26] owner_id, rest zero
   logic [rsrt_pkg::REQ_BITS-1:0] req_tdata = '0;
   // [1:0] action
   logic [1:0] req_tuser = rsrt_pkg::ACT_QUERY;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [0] done_res, [16:1] range_or, rest zero
   logic [rsrt_pkg::RSP_BITS-1:0] rsp_tdata;

   range_slot_reservation_tree u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // lowest bit is done_res, as on the result word
   typedef struct packed {
      logic [rsrt_pkg::OWNER_BITS-1:0] range_or;
      logic [0:0]                      done_res;
   } booking_result_type;

   typedef struct {
      rsrt_pkg::action_type            act;
      logic [rsrt_pkg::SLOT_BITS-1:0]  first;
      logic [rsrt_pkg::SLOT_BITS-1:0]  last;
      logic [rsrt_pkg::OWNER_BITS-1:0] owner;
      bit                              fixed;
      booking_result_type              want;
   } slot_request_type;

   // flat model of the slot owners
   logic [rsrt_pkg::OWNER_BITS-1:0] slot_owner [rsrt_pkg::NUM_SLOTS];
   booking_result_type    pending_results [$];
   booking_result_type    fixed_results [$];
   bit                    has_fixed [$];

   int  errors = 0;
   int  sent = 0;
   int  received = 0;
   int  booked = 0;
   int  cycles = 0;
   int  send_idle = 0;
   int  recv_stall = 0;

   function automatic booking_result_type apply_request(rsrt_pkg::action_type act,
         logic [rsrt_pkg::SLOT_BITS-1:0] first, logic [rsrt_pkg::SLOT_BITS-1:0] last,
         logic [rsrt_pkg::OWNER_BITS-1:0] owner);
      booking_result_type res;
      logic [rsrt_pkg::OWNER_BITS-1:0] acc;
      bit write_it;
      logic [rsrt_pkg::OWNER_BITS-1:0] val;
      acc = '0;
      write_it = 1'b0;
      val = owner;
      for (int s = first; s <= last; s++)
         acc |= slot_owner[s];
      res.range_or = acc;
      res.done_res = 1'b0;
      case (act)
         rsrt_pkg::ACT_BOOK: begin
            if (acc == '0) begin
               res.done_res = 1'b1;
               write_it = 1'b1;
            end
         end
         rsrt_pkg::ACT_RELEASE: begin
            if (acc == owner) begin
               res.done_res = 1'b1;
               write_it = 1'b1;
               val = '0;
            end
         end
         rsrt_pkg::ACT_ASSIGN: begin
            res.done_res = 1'b1;
            write_it = 1'b1;
         end
         default: ;
      endcase
      if (write_it)
         for (int s = first; s <= last; s++)
            slot_owner[s] = val;
      return res;
   endfunction

   // hand one word to the block and queue its expected result
   task automatic send_request(slot_request_type rq);
      booking_result_type res;
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.act;
      req_tdata  <= {rq.owner, rq.last, rq.first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = apply_request(rq.act, rq.first, rq.last, rq.owner);
      if (rq.fixed && res != rq.want)
         $display("%0t predictor disagrees with table: want %h got %h",
                  $time, rq.want, res);
      if (res.done_res && rq.act == rsrt_pkg::ACT_BOOK) booked++;
      pending_results = {pending_results, res};
      has_fixed = {has_fixed, rq.fixed};
      fixed_results = {fixed_results, rq.want};
      sent++;
   endtask

   // receiver side: random stalls and checking
   always @(posedge clock) begin
      booking_result_type got, exp_res, tab;
      bit fx;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[rsrt_pkg::OWNER_BITS:0];
            if (pending_results.size() == 0) begin
               $display("%0t unexpected result %h", $time, got);
               errors++;
            end else begin
               exp_res = pending_results.pop_front();
               fx = has_fixed.pop_front();
               tab = fixed_results.pop_front();
               if (fx) exp_res = tab;
               if (got.done_res !== exp_res.done_res) begin
                  $display("%0t done_res mismatch: expected %h actual %h",
                           $time, exp_res.done_res, got.done_res);
                  errors++;
               end
               if (got.range_or !== exp_res.range_or) begin
                  $display("%0t range_or mismatch: expected %h actual %h",
                           $time, exp_res.range_or, got.range_or);
                  errors++;
               end
               if (rsp_tdata[rsrt_pkg::RSP_BITS-1:rsrt_pkg::OWNER_BITS+1] !== '0) begin
                  $display("%0t padding mismatch: expected 0 actual %h", $time,
                           rsp_tdata[rsrt_pkg::RSP_BITS-1:rsrt_pkg::OWNER_BITS+1]);
                  errors++;
               end
            end
            received++;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // time-out guard: clearing pass plus worst-case walks under heavy stalls
   always @(posedge clock) begin
      if (cycles > 3_000_000) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic slot_request_type row(rsrt_pkg::action_type a, int f, int l, int o,
         bit fx = 1'b0, int dn = 0, int ro = 0);
      slot_request_type r;
      r.act = a;
      r.first = f[rsrt_pkg::SLOT_BITS-1:0];
      r.last = l[rsrt_pkg::SLOT_BITS-1:0];
      r.owner = o[rsrt_pkg::OWNER_BITS-1:0];
      r.fixed = fx;
      r.want.done_res = dn[0];
      r.want.range_or = ro[rsrt_pkg::OWNER_BITS-1:0];
      return r;
   endfunction

   // random range: mostly narrow, some wide, some empty or reversed
   task automatic random_request();
      slot_request_type r;
      int f, w, p, lv, ov;
      p = $urandom_range(99);
      f = $urandom_range(rsrt_pkg::NUM_SLOTS - 1);
      if (p < 60) w = $urandom_range(40);
      else if (p < 85) w = $urandom_range(rsrt_pkg::NUM_SLOTS - 1);
      else w = -int'($urandom_range(50)) - 1;
      r.first = f[rsrt_pkg::SLOT_BITS-1:0];
      lv = (f + w < 0) ? 0 : ((f + w > rsrt_pkg::NUM_SLOTS - 1) ?
           rsrt_pkg::NUM_SLOTS - 1 : f + w);
      r.last = lv[rsrt_pkg::SLOT_BITS-1:0];
      r.act = rsrt_pkg::action_type'($urandom_range(3));
      ov = $urandom;
      r.owner = ov[rsrt_pkg::OWNER_BITS-1:0];
      if ($urandom_range(9) == 0) r.owner = '0;
      // releases often name the current owner of the range
      if (r.act == rsrt_pkg::ACT_RELEASE && $urandom_range(3) != 0)
         r.owner = slot_owner[r.first];
      r.fixed = 1'b0;
      r.want = '0;
      send_request(r);
   endtask

   initial begin
      slot_request_type dir_rows [$];
      foreach (slot_owner[i]) slot_owner[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table; fixed rows carry results readable by eye
      dir_rows = '{
         row(rsrt_pkg::ACT_QUERY,   0, rsrt_pkg::NUM_SLOTS-1, 16'hFFFF, 1, 0, 0),
         row(rsrt_pkg::ACT_BOOK,    0, 0, 16'h0001, 1, 1, 0),
         row(rsrt_pkg::ACT_BOOK,    0, 0, 16'h0002, 1, 0, 16'h0001),
         row(rsrt_pkg::ACT_BOOK,    rsrt_pkg::NUM_SLOTS-1, rsrt_pkg::NUM_SLOTS-1,
             16'hFFFF, 1, 1, 0),
         row(rsrt_pkg::ACT_QUERY,   0, rsrt_pkg::NUM_SLOTS-1, 0, 1, 0, 16'hFFFF),
         row(rsrt_pkg::ACT_RELEASE, rsrt_pkg::NUM_SLOTS-1, rsrt_pkg::NUM_SLOTS-1,
             16'h0001, 1, 0, 16'hFFFF),
         row(rsrt_pkg::ACT_RELEASE, rsrt_pkg::NUM_SLOTS-1, rsrt_pkg::NUM_SLOTS-1,
             16'hFFFF, 1, 1, 16'hFFFF),
         row(rsrt_pkg::ACT_RELEASE, 100, 200, 0, 1, 1, 0),
         row(rsrt_pkg::ACT_BOOK,    300, 400, 0, 1, 1, 0),
         row(rsrt_pkg::ACT_QUERY,   10, 5, 0, 1, 0, 0),
         row(rsrt_pkg::ACT_BOOK,    10, 5, 16'h1234, 1, 1, 0),
         row(rsrt_pkg::ACT_RELEASE, 10, 5, 16'h1234, 1, 0, 0),
         row(rsrt_pkg::ACT_RELEASE, 10, 5, 0, 1, 1, 0),
         row(rsrt_pkg::ACT_ASSIGN,  10, 5, 16'h1234, 1, 1, 0),
         row(rsrt_pkg::ACT_ASSIGN,  1000, 5000, 16'hA5A5),
         row(rsrt_pkg::ACT_ASSIGN,  2000, 3000, 16'h5A5A),
         row(rsrt_pkg::ACT_QUERY,   999, 5001, 0),
         row(rsrt_pkg::ACT_RELEASE, 2000, 3000, 16'h5A5A),
         row(rsrt_pkg::ACT_BOOK,    2500, 2600, 16'h0F0F),
         row(rsrt_pkg::ACT_QUERY,   0, rsrt_pkg::NUM_SLOTS-1, 0),
         row(rsrt_pkg::ACT_ASSIGN,  0, rsrt_pkg::NUM_SLOTS-1, 0),
         row(rsrt_pkg::ACT_QUERY,   0, rsrt_pkg::NUM_SLOTS-1, 0, 1, 0, 0)
      };
      foreach (dir_rows[i]) send_request(dir_rows[i]);

      // random phases with different idling mixes
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: begin send_idle = 78; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 78; end
            3: begin send_idle = 12; recv_stall = 12; end
            default: begin send_idle = 0; recv_stall = 0; end
         endcase
         repeat (100) random_request();
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d words (%0d results, %0d successful books), all four actions,",
               sent, received, booked);
      $display("empty and reversed ranges, full-table ranges and varied idling");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/rsrt_pkg.sv
hw/rtl/range_slot_reservation_tree.sv
hw/rtl/rsrt_checker.sv
tb/tb_range_slot_reservation_tree.sv
